@@ hw/rtl/mtc_pkg.sv @@
`timescale 1ns / 1ps

package mtc_pkg;

  localparam int KEY_W = 32;
  localparam int OUT_IDX_W = 4;

  // Tag value held by every slot out of reset.
  localparam logic [KEY_W-1:0] TAG_RESET = 32'h7fff_ffff;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [OUT_IDX_W-1:0] out_idx_t;

endpackage

@@ hw/rtl/mtc_if.sv @@
`timescale 1ns / 1ps

interface mtc_req_if;
  import mtc_pkg::*;

  logic valid;
  logic ready;
  key_t key_x;
  key_t key_z;

  modport source (output valid, output key_x, output key_z, input ready);
  modport sink (input valid, input key_x, input key_z, output ready);
endinterface

interface mtc_rsp_if;
  import mtc_pkg::*;

  logic     valid;
  logic     ready;
  logic     hit;
  out_idx_t slot;
  out_idx_t old_position;

  modport source (output valid, output hit, output slot, output old_position, input ready);
  modport sink (input valid, input hit, input slot, input old_position, output ready);
endinterface

@@ hw/rtl/mtc_cell.sv @@
`timescale 1ns / 1ps

module mtc_cell #(
  parameter int SLOT_W = 4,
  parameter int IDX = 0,
  parameter type entry_t = logic,
  parameter type chain_t = logic
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          upd,
  input  mtc_pkg::key_t key_x,
  input  mtc_pkg::key_t key_z,
  input  entry_t        left_in,
  output entry_t        ent_o,
  input  chain_t        chain_in,
  output chain_t        chain_out,
  output logic          match_o
);
  import mtc_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;
  logic   match;

  assign match = ent_r.valid && (ent_r.tag_x == key_x) && (ent_r.tag_z == key_z);

  // Pass the first match down the row; a later cell never overrides it.
  always_comb begin
    chain_out = chain_in;
    if (!chain_in.hit && match) begin
      chain_out.hit = 1'b1;
      chain_out.slot = ent_r.slot;
      chain_out.pos = SLOT_W'(IDX);
    end
  end

  // On an accepted request, take the left entry unless a cell in front matched.
  always_comb begin
    ent_nxt = ent_r;
    if (upd && !chain_in.hit) begin
      ent_nxt = left_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
      ent_r.tag_x <= TAG_RESET;
      ent_r.tag_z <= TAG_RESET;
      ent_r.slot <= SLOT_W'(IDX);
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent_o = ent_r;
  assign match_o = match;

endmodule

@@ hw/rtl/mru_tag_cache_lookup_unit.sv @@
`timescale 1ns / 1ps

// Fully associative tag lookup with most-recently-used ordering. Each request
// word carries a signed coordinate pair (key_x, key_z); the response word tells
// whether the pair was found (hit), which storage slot now holds it (slot, where
// outside logic keeps the payload) and the recency position the slot held
// before the update (old_position; on a miss this is the last position). On a
// miss the least recently used slot is retagged with the new key. The tag array
// is a row of CACHE_ENTRIES cells kept in recency order: position 0 is the most
// recently used. All cells compare the key at once, the first match ripples
// down the row, and the cells in front of it shift one place back while the
// hit or victim slot enters at the front. Each response sits in an output
// register, so a request is accepted every cycle that the response register
// is empty or being drained; the limit is the compare, ripple and shift
// through the whole row. Slot and position are reported in their low 4
// bits. Out of reset every slot is empty and position p holds slot p; no
// clearing pass is needed.
module mru_tag_cache_lookup_unit #(
  parameter int CACHE_ENTRIES = 16
) (
  input logic     clk,
  input logic     rst_n,
  mtc_req_if.sink   in_req,
  mtc_rsp_if.source out_rsp
);
  import mtc_pkg::*;

  localparam int SLOT_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [SLOT_W-1:0] LAST_POS = SLOT_W'(CACHE_ENTRIES - 1);

  typedef struct packed {
    logic              valid;
    key_t              tag_x;
    key_t              tag_z;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] pos;
  } chain_t;

  entry_t                   ent     [CACHE_ENTRIES];
  entry_t                   left_in [CACHE_ENTRIES];
  chain_t                   chain   [CACHE_ENTRIES+1];
  logic [CACHE_ENTRIES-1:0] match_vec;

  logic              in_fire;
  logic              look_hit;
  logic [SLOT_W-1:0] look_slot;
  logic [SLOT_W-1:0] look_pos;
  entry_t            front;

  logic     out_valid_r, out_valid_nxt;
  logic     hit_r, hit_nxt;
  out_idx_t slot_r, slot_nxt;
  out_idx_t pos_r, pos_nxt;

  // Accept while the response register is free or being taken this cycle.
  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign in_fire = in_req.valid && in_req.ready;

  assign chain[0] = '0;

  // Hit: the matched slot goes to the front. Miss: the slot at the last
  // position is the victim. Either way the front cell ends up with the key.
  assign look_hit = chain[CACHE_ENTRIES].hit;
  assign look_slot = look_hit ? chain[CACHE_ENTRIES].slot : ent[CACHE_ENTRIES-1].slot;
  assign look_pos = look_hit ? chain[CACHE_ENTRIES].pos : LAST_POS;

  always_comb begin
    front.valid = 1'b1;
    front.tag_x = in_req.key_x;
    front.tag_z = in_req.key_z;
    front.slot = look_slot;
  end

  for (genvar p = 0; p < CACHE_ENTRIES; p++) begin : g_row
    if (p == 0) begin : g_head
      assign left_in[p] = front;
    end else begin : g_body
      assign left_in[p] = ent[p-1];
    end

    mtc_cell #(
      .SLOT_W  (SLOT_W),
      .IDX     (p),
      .entry_t (entry_t),
      .chain_t (chain_t)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .upd       (in_fire),
      .key_x     (in_req.key_x),
      .key_z     (in_req.key_z),
      .left_in   (left_in[p]),
      .ent_o     (ent[p]),
      .chain_in  (chain[p]),
      .chain_out (chain[p+1]),
      .match_o   (match_vec[p])
    );
  end

  // Report only the low 4 bits of slot and position.
  logic [SLOT_W+OUT_IDX_W-1:0] slot_ext;
  logic [SLOT_W+OUT_IDX_W-1:0] pos_ext;
  assign slot_ext = {{OUT_IDX_W{1'b0}}, look_slot};
  assign pos_ext = {{OUT_IDX_W{1'b0}}, look_pos};

  // Hold the response word until taken; load a new one on each accepted request.
  always_comb begin
    out_valid_nxt = out_valid_r;
    hit_nxt = hit_r;
    slot_nxt = slot_r;
    pos_nxt = pos_r;
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      hit_nxt = look_hit;
      slot_nxt = slot_ext[OUT_IDX_W-1:0];
      pos_nxt = pos_ext[OUT_IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    slot_r <= slot_nxt;
    pos_r <= pos_nxt;
  end

  assign out_rsp.valid = out_valid_r;
  assign out_rsp.hit = hit_r;
  assign out_rsp.slot = slot_r;
  assign out_rsp.old_position = pos_r;

  logic [SLOT_W+OUT_IDX_W-1:0] front_slot_ext;
  assign front_slot_ext = {{OUT_IDX_W{1'b0}}, ent[0].slot};

  // The old copy of a key shifts out as it enters, so no two cells ever match.
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("more than one cell matched the key");

  // The accepted key sits valid in the front cell in the next cycle.
  a_front_key: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> ent[0].valid && ent[0].tag_x == $past(in_req.key_x)
                && ent[0].tag_z == $past(in_req.key_z))
    else $error("front cell does not hold the last accepted key");

  // The reported slot is the one now at the front.
  a_front_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_rsp.valid && out_rsp.slot == front_slot_ext[OUT_IDX_W-1:0])
    else $error("reported slot differs from the front cell");

  // A miss reports the last position.
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !look_hit |=> !out_rsp.hit
      && out_rsp.old_position == pos_ext[OUT_IDX_W-1:0] - pos_ext[OUT_IDX_W-1:0]
         + $past(pos_ext[OUT_IDX_W-1:0]))
    else $error("miss response carries a wrong position");

endmodule
